>>> hdl/spq_pkg.sv
// Shared types, sizes and codes of the sorted priority queue.
package spq_pkg;

    // Number of entries the queue can hold.
    localparam int DEPTH = 16;
    // Width of the entry count, which must be able to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Fixed field widths of the beats.
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 5;
    localparam int STS_W  = 2;

    // Operation codes carried by an input beat.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_ENQUEUED = 2'd0,
        STS_DEQUEUED = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_FULL     = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input beat
        logic execute;  // apply the captured operation and load the result
    } t_dp_cmd;

endpackage

>>> hdl/spq_in_if.sv
// Input channel of the sorted priority queue: operation and entry.
interface spq_in_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] item_data;
    logic        [PRIO_W-1:0] item_priority;

    modport source (output valid, output operation, output item_data,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_data,
                    input item_priority, output ready);
endinterface

>>> hdl/spq_out_if.sv
// Output channel of the sorted priority queue: status, head entry and occupancy.
interface spq_out_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [STS_W-1:0]  status;
    logic signed [DATA_W-1:0] head_data;
    logic        [PRIO_W-1:0] head_priority;
    logic        [OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output head_data,
                    output head_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input head_data,
                    input head_priority, input occupancy, output ready);
endinterface

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
//
// Holds up to DEPTH entries (data word and priority) in ascending priority
// order, first in first out among equal priorities. Each input beat carries
// an operation: enqueue the carried entry, or dequeue the head entry.
// Every input beat yields exactly one result beat with a status, the removed
// entry on a successful dequeue (zeros otherwise) and the occupancy after it.
// An enqueue to a full queue is dropped and reported; a dequeue on an empty
// queue is reported and changes nothing.
// A beat accepted at an edge is captured, applied to the cell chain in the
// execute state that follows, and its result is registered at the end of
// that state and held on the output. No new beat is taken while one is
// being executed: each operation passes through the capture and execute
// steps of the controller around the single shifting cell chain.
// Reset (synchronous, active low) empties the queue and drops any pending
// result. If the receiver stalls, the result beat holds and no further
// input beat is taken until the result is taken.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    t_dp_cmd cmd;

    // Sequencing and handshakes.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Cell chain and result register.
    spq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_in.operation),
        .i_item_data     (i_in.item_data),
        .i_item_priority (i_in.item_priority),
        .o_status        (o_out.status),
        .o_head_data     (o_out.head_data),
        .o_head_priority (o_out.head_priority),
        .o_occupancy     (o_out.occupancy)
    );

endmodule

>>> hdl/spq_ctrl.sv
// Controller of the sorted priority queue: beat handshakes and sequencing.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // A new beat is taken when idle and the result register is free by the next edge.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The result beat becomes valid after execution and holds until taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/spq_dp.sv
// Datapath of the sorted priority queue: a chain of shifting cells and the result register.
module spq_dp
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_item_data,
    input  logic        [PRIO_W-1:0] i_item_priority,
    output logic        [STS_W-1:0]  o_status,
    output logic signed [DATA_W-1:0] o_head_data,
    output logic        [PRIO_W-1:0] o_head_priority,
    output logic        [OCC_W-1:0]  o_occupancy
);

    // Cell chain, ordered by ascending priority from cell 0.
    logic        [PRIO_W-1:0] r_prio [DEPTH];
    logic signed [DATA_W-1:0] r_word [DEPTH];
    logic        [PRIO_W-1:0] n_prio [DEPTH];
    logic signed [DATA_W-1:0] n_word [DEPTH];
    logic        [CNT_W-1:0]  r_count, n_count;

    // Captured input beat.
    logic                     r_op;
    logic signed [DATA_W-1:0] r_data;
    logic        [PRIO_W-1:0] r_pri;

    // Result register.
    t_status                  r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic        [PRIO_W-1:0] r_out_prio, n_out_prio;
    logic        [OCC_W-1:0]  r_out_occ, n_out_occ;

    logic             full;
    logic             empty;
    logic [DEPTH-1:0] le;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Each held cell flags whether the new entry belongs behind it.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = (CNT_W'(i) < r_count) && (r_prio[i] <= r_pri);
        end
    end

    // Next contents of the chain and the result.
    always_comb begin
        n_prio       = r_prio;
        n_word       = r_word;
        n_count      = r_count;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_prio   = r_out_prio;
        n_out_occ    = r_out_occ;
        if (i_cmd.execute) begin
            n_out_data = '0;
            n_out_prio = '0;
            if (r_op == OP_ENQ) begin
                if (full) begin
                    n_out_status = STS_FULL;
                end else begin
                    // The first cell not flagged takes the entry; the ones after it shift up.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!le[i]) begin
                            if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                                n_prio[i] = r_pri;
                                n_word[i] = r_data;
                            end else begin
                                n_prio[i] = r_prio[(i == 0) ? 0 : i - 1];
                                n_word[i] = r_word[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                    n_count      = r_count + CNT_W'(1);
                    n_out_status = STS_ENQUEUED;
                end
            end else begin
                if (empty) begin
                    n_out_status = STS_EMPTY;
                end else begin
                    // The head leaves and every cell behind it moves one place down.
                    n_out_data = r_word[0];
                    n_out_prio = r_prio[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_prio[i] = r_prio[i + 1];
                        n_word[i] = r_word[i + 1];
                    end
                    n_count      = r_count - CNT_W'(1);
                    n_out_status = STS_DEQUEUED;
                end
            end
            n_out_occ = OCC_W'(n_count);
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_data <= i_item_data;
            r_pri  <= i_item_priority;
        end
        r_prio       <= n_prio;
        r_word       <= n_word;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_prio   <= n_out_prio;
        r_out_occ    <= n_out_occ;
    end

    assign o_status        = r_out_status;
    assign o_head_data     = r_out_data;
    assign o_head_priority = r_out_prio;
    assign o_occupancy     = r_out_occ;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // A dequeue on an empty queue reports empty and leaves the count alone.
    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && (r_op == OP_DEQ) && empty
        |=> (r_out_status == STS_EMPTY) && $stable(r_count))
        else $error("dequeue on empty changed the queue");

    // An accepted enqueue grows the count by one.
    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && (r_op == OP_ENQ) && !full
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("enqueue did not grow the count");

    // The reported occupancy matches the count after each operation.
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> r_out_occ == OCC_W'(r_count))
        else $error("occupancy differs from the entry count");

endmodule

>>> tb/sv/spq_order_checker.sv
// Watches both channels of the sorted priority queue, predicts each result beat and compares it.
`timescale 1ns / 1ps

module spq_order_checker
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_in_mon,
    spq_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    // One held entry of the predicted queue.
    typedef struct {
        logic signed [DATA_W-1:0] word;
        logic        [PRIO_W-1:0] prio;
    } t_entry;

    // One predicted result beat.
    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
        logic        [OCC_W-1:0]  occ;
    } t_result;

    // Predicted queue contents, head first, and results still owed by the block.
    t_entry  held_entries[$];
    t_result expected_results[$];
    int      fail_total = 0;

    // Applies one operation to the predicted queue and returns the result it causes.
    function automatic t_result apply_operation(input logic                     op,
                                                input logic signed [DATA_W-1:0] word,
                                                input logic        [PRIO_W-1:0] prio);
        t_result r;
        t_entry  e;
        int      pos;
        r.status = STS_ENQUEUED;
        r.data   = '0;
        r.prio   = '0;
        if (op == OP_ENQ) begin
            if (held_entries.size() >= DEPTH) begin
                r.status = STS_FULL;
            end else begin
                // The new entry goes behind every entry of equal or lower priority.
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].prio <= prio)
                    pos++;
                e.word = word;
                e.prio = prio;
                held_entries.insert(pos, e);
            end
        end else begin
            if (held_entries.size() == 0) begin
                r.status = STS_EMPTY;
            end else begin
                e        = held_entries.pop_front();
                r.status = STS_DEQUEUED;
                r.data   = e.word;
                r.prio   = e.prio;
            end
        end
        r.occ = OCC_W'(held_entries.size());
        return r;
    endfunction

    // Predict on every accepted input beat and compare every accepted result beat.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                expected_results.push_back(apply_operation(i_in_mon.operation,
                                                           i_in_mon.item_data,
                                                           i_in_mon.item_priority));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result beat with nothing expected, status %0d",
                                 $realtime, i_out_mon.status);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_mon.status !== want.status || i_out_mon.head_data !== want.data ||
                        i_out_mon.head_priority !== want.prio ||
                        i_out_mon.occupancy !== want.occ) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: mismatch: status exp %0d got %0d, data exp %0d got %0d,",
                                     $realtime, want.status, i_out_mon.status,
                                     want.data, i_out_mon.head_data);
                            $display("    priority exp %0d got %0d, occupancy exp %0d got %0d",
                                     want.prio, i_out_mon.head_priority,
                                     want.occ, i_out_mon.occupancy);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

>>> tb/sv/sorted_priority_queue_tb.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    // Idle percentages per flow-control phase: none, sender idle, receiver stall, both.
    localparam int SEND_IDLE[4]  = '{0, 68, 0, 11};
    localparam int RECV_STALL[4] = '{0, 0, 68, 11};
    // Share of enqueues per random chunk, so the queue swings between empty and full.
    localparam int ENQ_BIAS[8]   = '{75, 30, 55, 80, 25, 50, 70, 35};
    localparam int CHUNK_BEATS   = 225;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   fail_count;
    int   pending_results;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spq_order_checker u_order_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Random priorities lean on a few small values so that ties are common.
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return PRIO_W'($urandom);
            default: return PRIO_W'($urandom_range(5));
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Sends one beat after a random idle gap; returns at the falling edge after acceptance.
    task automatic send_beat(input logic                     op,
                             input logic signed [DATA_W-1:0] word,
                             input logic        [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.item_data     <= word;
        in_ch.item_priority <= prio;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Run limit.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_ENQ;
        in_ch.item_data     = '0;
        in_ch.item_priority = '0;
        out_ch.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Dequeue on an empty queue.
        send_beat(OP_DEQ, 32'sh7FFF_FFFF, '1);
        // Fill past full with extreme words and repeated priorities at both ends.
        for (int k = 0; k < DEPTH + 1; k++) begin
            send_beat(OP_ENQ,
                      k[0] ? 32'sh7FFF_FFFF - k : 32'sh8000_0000 + k,
                      (k % 4 == 0) ? 16'd0 : (k % 4 == 1) ? 16'hFFFF : 16'd7);
        end
        // Drain a few; the head must come out lowest priority first, oldest first.
        send_beat(OP_DEQ, '0, '0);
        for (int k = 0; k < 5; k++)
            send_beat(OP_DEQ, $urandom, PRIO_W'($urandom));

        // Random operations in chunks, cycling through the flow-control phases.
        for (int chunk = 0; chunk < 8; chunk++) begin
            send_idle_pct  = SEND_IDLE[chunk % 4];
            recv_stall_pct = RECV_STALL[chunk % 4];
            for (int n = 0; n < CHUNK_BEATS; n++) begin
                if ($urandom_range(99) < ENQ_BIAS[chunk])
                    send_beat(OP_ENQ, pick_word(), pick_priority());
                else
                    send_beat(OP_DEQ, $urandom, PRIO_W'($urandom));
            end
        end
        in_ch.valid <= 1'b0;
        recv_stall_pct = 0;

        // Wait for the last results, then wait out any stray result beats.
        while (pending_results != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/spq_pkg.sv
hdl/spq_in_if.sv
hdl/spq_out_if.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/sorted_priority_queue.sv
tb/sv/spq_order_checker.sv
tb/sv/sorted_priority_queue_tb.sv
